// ----- src/kspb_pkg.sv -----
// ----------------------------------------------------------------------------
// kspb_pkg
// Shared types and constants for the knight shortest path search block.
// ----------------------------------------------------------------------------
package kspb_pkg;

    // Field widths
    localparam int COORD_W    = 6;   // query coordinates
    localparam int SIZE_W     = 7;   // board size registers, internal coordinates
    localparam int COUNT_W    = 12;  // move count
    localparam int CFG_IDX_W  = 4;   // configuration register index
    localparam int CFG_DATA_W = 7;   // configuration write data

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOARD_ROWS = 4'd0,
        REG_BOARD_COLS = 4'd1
    } cfg_reg_t;

    // Board size as seen by the search engine
    typedef struct packed {
        logic [SIZE_W-1:0] rows;
        logic [SIZE_W-1:0] cols;
    } board_t;

    // Knight offsets, two's complement, tried in this order
    localparam logic [2:0] STEP_ROW [8] = '{3'd2, 3'd2, 3'd1, 3'd1,
                                           3'h7, 3'h7, 3'h6, 3'h6};
    localparam logic [2:0] STEP_COL [8] = '{3'h7, 3'd1, 3'h6, 3'd2,
                                           3'h6, 3'd2, 3'h7, 3'd1};

endpackage

// ----- src/kspb_ifs.sv -----
// ----------------------------------------------------------------------------
// kspb_ifs
// Valid/ready channels for queries, results and configuration writes.
// ----------------------------------------------------------------------------

interface kspb_query_if;
    import kspb_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] start_row;
    logic [COORD_W-1:0] start_col;
    logic [COORD_W-1:0] end_row;
    logic [COORD_W-1:0] end_col;

    modport source (output valid, start_row, start_col, end_row, end_col,
                    input ready);
    modport sink   (input valid, start_row, start_col, end_row, end_col,
                    output ready);
endinterface

interface kspb_result_if;
    import kspb_pkg::*;
    logic               valid;
    logic               ready;
    logic               found;
    logic [COUNT_W-1:0] move_count;

    modport source (output valid, found, move_count, input ready);
    modport sink   (input valid, found, move_count, output ready);
endinterface

interface kspb_cfg_if;
    import kspb_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_data;

    modport source (output valid, reg_index, reg_data, input ready);
    modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

// ----- src/kspb_cfg.sv -----
// ----------------------------------------------------------------------------
// kspb_cfg
// Board size registers, saturated to the configured maximum board.
// ----------------------------------------------------------------------------
module kspb_cfg #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    kspb_cfg_if.sink         cfg,
    output kspb_pkg::board_t board
);
    import kspb_pkg::*;

    localparam int RST_ROWS = (MAX_ROWS < 8) ? MAX_ROWS : 8;
    localparam int RST_COLS = (MAX_COLS < 8) ? MAX_COLS : 8;

    logic [SIZE_W-1:0] rows_reg, rows_next;
    logic [SIZE_W-1:0] cols_reg, cols_next;
    logic              wr;

    // Writes are always taken
    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid;

    // Decode and saturate
    always_comb
    begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (wr && cfg.reg_index == REG_BOARD_ROWS)
        begin
            rows_next = (32'(cfg.reg_data) > MAX_ROWS) ? SIZE_W'(MAX_ROWS) : cfg.reg_data;
        end
        if (wr && cfg.reg_index == REG_BOARD_COLS)
        begin
            cols_next = (32'(cfg.reg_data) > MAX_COLS) ? SIZE_W'(MAX_COLS) : cfg.reg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= SIZE_W'(RST_ROWS);
            cols_reg <= SIZE_W'(RST_COLS);
        end
        else
        begin
            rows_reg <= rows_next;
            cols_reg <= cols_next;
        end
    end

    assign board.rows = rows_reg;
    assign board.cols = cols_reg;

endmodule

// ----- src/kspb_search.sv -----
// ----------------------------------------------------------------------------
// kspb_search
// Breadth-first search sequencer around a visited map and a square queue.
// ----------------------------------------------------------------------------
module kspb_search #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  kspb_pkg::board_t board,
    kspb_query_if.sink       query,
    kspb_result_if.source    result
);
    import kspb_pkg::*;

    // Coordinates never exceed the 7-bit board size registers
    localparam int ROW_LIM = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
    localparam int COL_LIM = (MAX_COLS > 127) ? 127 : MAX_COLS;
    localparam int RA_W    = (ROW_LIM > 1) ? $clog2(ROW_LIM) : 1;
    localparam int CA_W    = (COL_LIM > 1) ? $clog2(COL_LIM) : 1;
    localparam int AW      = RA_W + CA_W;
    localparam int DEPTH   = 1 << AW;
    localparam int PTR_W   = AW + 1;

    typedef struct packed {
        logic [SIZE_W-1:0]  row;
        logic [SIZE_W-1:0]  col;
        logic [COUNT_W-1:0] hops;
    } entry_t;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CLEAR = 8'b0000_0010,
        S_SEED  = 8'b0000_0100,
        S_POP   = 8'b0000_1000,
        S_CHECK = 8'b0001_0000,
        S_NADDR = 8'b0010_0000,
        S_NTEST = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    function automatic logic [AW-1:0] sq_addr(input logic [SIZE_W-1:0] r,
                                              input logic [SIZE_W-1:0] c);
        return {r[RA_W-1:0], c[CA_W-1:0]};
    endfunction

    // Memories
    logic    vis_mem [DEPTH];
    entry_t  q_mem   [DEPTH];

    logic          vis_we, vis_wdata, vis_rdata_reg;
    logic [AW-1:0] vis_waddr, vis_raddr;
    logic          q_we;
    logic [AW-1:0] q_waddr, q_raddr;
    entry_t        q_wdata, q_rdata_reg;

    // Control and payload registers
    state_t             state_reg, state_next;
    logic [SIZE_W-1:0]  sr_reg, sr_next, sc_reg, sc_next;
    logic [SIZE_W-1:0]  er_reg, er_next, ec_reg, ec_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [PTR_W-1:0]   head_reg, head_next, tail_reg, tail_next;
    entry_t             cur_reg, cur_next;
    logic [2:0]         k_reg, k_next;
    logic [SIZE_W-1:0]  nbr_reg, nbr_next, nbc_reg, nbc_next;
    logic               nbok_reg, nbok_next;
    logic               fnd_reg, fnd_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_found_reg, out_found_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;

    // Query fields widened to the internal coordinate width
    logic [SIZE_W-1:0] q_sr, q_sc, q_er, q_ec;
    logic              q_on_board, q_same;

    // Neighbor arithmetic, 9-bit two's complement
    logic [8:0]         nr_sum, nc_sum;
    logic               nr_ok, nc_ok;
    logic [COUNT_W-1:0] dist_inc;

    assign q_sr = SIZE_W'(query.start_row);
    assign q_sc = SIZE_W'(query.start_col);
    assign q_er = SIZE_W'(query.end_row);
    assign q_ec = SIZE_W'(query.end_col);
    assign q_on_board = (q_sr < board.rows) && (q_sc < board.cols) &&
                        (q_er < board.rows) && (q_ec < board.cols);
    assign q_same     = (q_sr == q_er) && (q_sc == q_ec);

    assign nr_sum = {2'b00, cur_reg.row} + {{6{STEP_ROW[k_reg][2]}}, STEP_ROW[k_reg]};
    assign nc_sum = {2'b00, cur_reg.col} + {{6{STEP_COL[k_reg][2]}}, STEP_COL[k_reg]};
    assign nr_ok  = !nr_sum[8] && (nr_sum[7:0] < {1'b0, board.rows});
    assign nc_ok  = !nc_sum[8] && (nc_sum[7:0] < {1'b0, board.cols});

    assign dist_inc = (cur_reg.hops == COUNT_MAX) ? COUNT_MAX : cur_reg.hops + 1'b1;

    assign query.ready       = (state_reg == S_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.found      = out_found_reg;
    assign result.move_count = out_count_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        sr_next        = sr_reg;
        sc_next        = sc_reg;
        er_next        = er_reg;
        ec_next        = ec_reg;
        clr_next       = clr_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cur_next       = cur_reg;
        k_next         = k_reg;
        nbr_next       = nbr_reg;
        nbc_next       = nbc_reg;
        nbok_next      = nbok_reg;
        fnd_next       = fnd_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_found_next = out_found_reg;
        out_count_next = out_count_reg;

        vis_we    = 1'b0;
        vis_waddr = sq_addr(nbr_reg, nbc_reg);
        vis_wdata = 1'b1;
        vis_raddr = sq_addr(nr_sum[SIZE_W-1:0], nc_sum[SIZE_W-1:0]);
        q_we      = 1'b0;
        q_waddr   = tail_reg[AW-1:0];
        q_wdata   = '{row: nbr_reg, col: nbc_reg, hops: dist_inc};
        q_raddr   = head_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (query.valid)
                begin
                    sr_next  = q_sr;
                    sc_next  = q_sc;
                    er_next  = q_er;
                    ec_next  = q_ec;
                    cnt_next = '0;
                    clr_next = '0;
                    if (!q_on_board)
                    begin
                        fnd_next   = 1'b0;
                        state_next = S_DONE;
                    end
                    else if (q_same)
                    begin
                        fnd_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_CLEAR;
                    end
                end
            end

            // Sweep the visited map, one entry a cycle
            S_CLEAR:
            begin
                vis_we    = 1'b1;
                vis_waddr = clr_reg;
                vis_wdata = 1'b0;
                clr_next  = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = S_SEED;
                end
            end

            // Start square goes in as entry zero
            S_SEED:
            begin
                vis_we     = 1'b1;
                vis_waddr  = sq_addr(sr_reg, sc_reg);
                q_we       = 1'b1;
                q_waddr    = '0;
                q_wdata    = '{row: sr_reg, col: sc_reg, hops: '0};
                head_next  = '0;
                tail_next  = PTR_W'(1);
                state_next = S_POP;
            end

            S_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    fnd_next   = 1'b0;
                    cnt_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    head_next  = head_reg + 1'b1;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                cur_next = q_rdata_reg;
                k_next   = '0;
                if (q_rdata_reg.row == er_reg && q_rdata_reg.col == ec_reg)
                begin
                    fnd_next   = 1'b1;
                    cnt_next   = q_rdata_reg.hops;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_NADDR;
                end
            end

            // Neighbor address issued to the visited map
            S_NADDR:
            begin
                nbr_next   = nr_sum[SIZE_W-1:0];
                nbc_next   = nc_sum[SIZE_W-1:0];
                nbok_next  = nr_ok && nc_ok;
                state_next = S_NTEST;
            end

            // Mark and enqueue a fresh neighbor
            S_NTEST:
            begin
                if (nbok_reg && !vis_rdata_reg)
                begin
                    vis_we    = 1'b1;
                    q_we      = 1'b1;
                    tail_next = tail_reg + 1'b1;
                end
                k_next     = k_reg + 1'b1;
                state_next = (&k_reg) ? S_POP : S_NADDR;
            end

            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = fnd_reg;
                    out_count_next = fnd_reg ? cnt_reg : '0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sr_reg        <= sr_next;
        sc_reg        <= sc_next;
        er_reg        <= er_next;
        ec_reg        <= ec_next;
        clr_reg       <= clr_next;
        cur_reg       <= cur_next;
        k_reg         <= k_next;
        nbr_reg       <= nbr_next;
        nbc_reg       <= nbc_next;
        nbok_reg      <= nbok_next;
        fnd_reg       <= fnd_next;
        cnt_reg       <= cnt_next;
        out_found_reg <= out_found_next;
        out_count_reg <= out_count_next;
    end

    // Visited map
    always_ff @(posedge clk)
    begin
        if (vis_we)
        begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
        vis_rdata_reg <= vis_mem[vis_raddr];
    end

    // Square queue
    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[q_waddr] <= q_wdata;
        end
        q_rdata_reg <= q_mem[q_raddr];
    end

    // Checks
    a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("queue head passed tail");

    a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= PTR_W'(DEPTH))
        else $error("queue overflow");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_found_reg |-> out_count_reg == '0)
        else $error("nonzero count on a miss");

    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result loaded outside done state");

endmodule

// ----- src/knight_shortest_path_bfs_top.sv -----
// Each query takes a start and an end square and returns the fewest knight
// moves between them on a board of board_rows by board_cols squares. A query
// with a square off the board, or with start equal to end, goes straight to
// the done state without a search. Any other query first clears the visited
// map, one entry a cycle (2^(ceil(log2 MAX_ROWS) + ceil(log2 MAX_COLS))
// entries, 4096 at the default 64x64 maximum), then seeds the search with the
// start square. Each dequeued square is popped and read, then tested against
// the target; for a square that is not the target, each of the eight knight
// moves reads the visited map and then marks and enqueues a fresh neighbor.
// An unreachable target is reported when the queue runs dry. One query is
// in flight at a time; the result sits in an output register, so the next
// query is taken as soon as the result is loaded. Board size writes are
// always accepted and take effect at once, so they must only be made while
// no query is in flight.
// ----------------------------------------------------------------------------
// knight_shortest_path_bfs_top
// Knight shortest path search: configuration registers and search engine.
// ----------------------------------------------------------------------------
module knight_shortest_path_bfs_top #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    kspb_cfg_if.sink      cfg,
    kspb_query_if.sink    query,
    kspb_result_if.source result
);
    import kspb_pkg::*;

    board_t board;

    // Board size registers
    kspb_cfg #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .board (board)
    );

    // Search engine
    kspb_search #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_search (
        .clk    (clk),
        .rst_n  (rst_n),
        .board  (board),
        .query  (query),
        .result (result)
    );

endmodule

// ----- tb/kspb_path_checker.sv -----
// ----------------------------------------------------------------------------
// kspb_path_checker
// Watches the configuration, query and result channels of the knight path
// search block. It keeps its own copy of the board size, works out the fewest
// knight moves for every accepted query by breadth-first search, and compares
// each accepted result with the oldest answer still owed.
// ----------------------------------------------------------------------------
module kspb_path_checker #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic   clk,
    input  logic   rst_n,
    kspb_cfg_if    cfg,
    kspb_query_if  query,
    kspb_result_if result,
    output int     fail_count,
    output int     pending,
    output int     checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import kspb_pkg::*;

    localparam int SQUARES = MAX_ROWS * MAX_COLS;

    // One answer owed by the block, with the query that asked for it
    typedef struct {
        int                 query_id;
        logic [COORD_W-1:0] sr;
        logic [COORD_W-1:0] sc;
        logic [COORD_W-1:0] er;
        logic [COORD_W-1:0] ec;
        logic               found;
        logic [COUNT_W-1:0] move_count;
    } path_answer_t;

    int row_step [8] = '{2, 2, 1, 1, -1, -1, -2, -2};
    int col_step [8] = '{-1, 1, -2, 2, -2, 2, -1, 1};

    // Board size as the block should see it
    int board_rows = 8;
    int board_cols = 8;

    // Search scratch: visited squares and the frontier queue
    bit seen     [SQUARES];
    int hop_row  [SQUARES];
    int hop_col  [SQUARES];
    int hop_dist [SQUARES];

    path_answer_t expected_answers [$];
    int           query_count;

    initial
    begin
        fail_count  = 0;
        checked     = 0;
        pending     = 0;
        query_count = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        fail_count++;
    endtask

    function automatic int clamp_size(input logic [CFG_DATA_W-1:0] v, input int maxv);
        return (int'(v) > maxv) ? maxv : int'(v);
    endfunction

    // Fewest knight moves from start to end; found is 0 when off board or unreachable
    function automatic path_answer_t knight_distance(input int rows, input int cols,
                                                     input int sr, input int sc,
                                                     input int er, input int ec);
        path_answer_t ans;
        int head;
        int tail;
        int cr;
        int cc;
        int cd;
        int nr;
        int nc;
        int k;
        ans.found      = 1'b0;
        ans.move_count = '0;
        if (!(sr < rows && sc < cols && er < rows && ec < cols))
            return ans;
        if (sr == er && sc == ec)
        begin
            ans.found = 1'b1;
            return ans;
        end
        foreach (seen[i])
            seen[i] = 1'b0;
        hop_row[0]  = sr;
        hop_col[0]  = sc;
        hop_dist[0] = 0;
        seen[sr * MAX_COLS + sc] = 1'b1;
        head = 0;
        tail = 1;
        while (head < tail)
        begin
            cr = hop_row[head];
            cc = hop_col[head];
            cd = hop_dist[head];
            head++;
            if (cr == er && cc == ec)
            begin
                ans.found      = 1'b1;
                ans.move_count = (cd > int'(COUNT_MAX)) ? COUNT_MAX : cd[COUNT_W-1:0];
                return ans;
            end
            for (k = 0; k < 8; k++)
            begin
                nr = cr + row_step[k];
                nc = cc + col_step[k];
                if (nr < 0 || nc < 0 || nr >= rows || nc >= cols)
                    continue;
                if (seen[nr * MAX_COLS + nc])
                    continue;
                seen[nr * MAX_COLS + nc] = 1'b1;
                if (tail < SQUARES)
                begin
                    hop_row[tail]  = nr;
                    hop_col[tail]  = nc;
                    hop_dist[tail] = cd + 1;
                    tail++;
                end
            end
        end
        return ans;
    endfunction

    // Follow the handshakes; results are retired before new queries are queued
    always @(posedge clk)
    begin
        path_answer_t want;
        path_answer_t next;
        if (!rst_n)
        begin
            board_rows = (8 > MAX_ROWS) ? MAX_ROWS : 8;
            board_cols = (8 > MAX_COLS) ? MAX_COLS : 8;
            expected_answers.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.reg_index == REG_BOARD_ROWS)
                    board_rows = clamp_size(cfg.reg_data, MAX_ROWS);
                else if (cfg.reg_index == REG_BOARD_COLS)
                    board_cols = clamp_size(cfg.reg_data, MAX_COLS);
            end

            if (result.valid && result.ready)
            begin
                if (expected_answers.size() == 0)
                    report_mismatch($sformatf(
                        "result found=%0d move_count=%0d with no query open",
                        result.found, result.move_count));
                else
                begin
                    want = expected_answers.pop_front();
                    checked++;
                    if (result.found !== want.found)
                        report_mismatch($sformatf(
                            "query %0d (%0d,%0d)->(%0d,%0d) found %0d, expected %0d",
                            want.query_id, want.sr, want.sc, want.er, want.ec,
                            result.found, want.found));
                    if (result.move_count !== want.move_count)
                        report_mismatch($sformatf(
                            "query %0d (%0d,%0d)->(%0d,%0d) move_count %0d, expected %0d",
                            want.query_id, want.sr, want.sc, want.er, want.ec,
                            result.move_count, want.move_count));
                end
            end

            if (query.valid && query.ready)
            begin
                next = knight_distance(board_rows, board_cols,
                                       int'(query.start_row), int'(query.start_col),
                                       int'(query.end_row), int'(query.end_col));
                next.query_id = query_count;
                next.sr       = query.start_row;
                next.sc       = query.start_col;
                next.er       = query.end_row;
                next.ec       = query.end_col;
                expected_answers.push_back(next);
                query_count++;
            end

            pending <= expected_answers.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the knight path search block. Runs directed
// corner queries on the reset board, then a series of board sizes (empty,
// single square, unreachable center, saturated rows, full 64x64) and random
// small boards, with random gaps on both channels. The checker does the
// prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kspb_pkg::*;

    localparam int MAX_ROWS     = 64;
    localparam int MAX_COLS     = 64;
    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int COORD_MAX    = (1 << COORD_W) - 1;

    // Index past the register list; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd14;

    logic clk = 1'b0;
    logic rst_n;

    int fail_count;
    int pending_answers;
    int checked_count;

    int  board_rows = 8;
    int  board_cols = 8;
    int  board_settings = 1;
    bit  query_calm = 1'b0;
    bit  result_calm = 1'b0;

    kspb_cfg_if    cfg_ch ();
    kspb_query_if  query_ch ();
    kspb_result_if result_ch ();

    knight_shortest_path_bfs_top #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .query  (query_ch),
        .result (result_ch)
    );

    kspb_path_checker #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_ch),
        .query      (query_ch),
        .result     (result_ch),
        .fail_count (fail_count),
        .pending    (pending_answers),
        .checked    (checked_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Send one query after a random gap; valid stays high on return
    task automatic send_query(input logic [COORD_W-1:0] sr, input logic [COORD_W-1:0] sc,
                              input logic [COORD_W-1:0] er, input logic [COORD_W-1:0] ec);
        int gap;
        gap = query_calm ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 11) == 0)
            query_calm = !query_calm;
        if (gap > 0)
        begin
            query_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        query_ch.valid     <= 1'b1;
        query_ch.start_row <= sr;
        query_ch.start_col <= sc;
        query_ch.end_row   <= er;
        query_ch.end_col   <= ec;
        do @(posedge clk); while (!query_ch.ready);
    endtask

    // Mostly on-board squares, sometimes anywhere, now and then start equal to end
    task automatic random_query();
        logic [COORD_W-1:0] sr;
        logic [COORD_W-1:0] sc;
        logic [COORD_W-1:0] er;
        logic [COORD_W-1:0] ec;
        if (board_rows > 0 && board_cols > 0 && $urandom_range(0, 5) != 0)
        begin
            sr = COORD_W'($urandom_range(0, board_rows - 1));
            sc = COORD_W'($urandom_range(0, board_cols - 1));
            er = COORD_W'($urandom_range(0, board_rows - 1));
            ec = COORD_W'($urandom_range(0, board_cols - 1));
        end
        else
        begin
            sr = COORD_W'($urandom_range(0, COORD_MAX));
            sc = COORD_W'($urandom_range(0, COORD_MAX));
            er = COORD_W'($urandom_range(0, COORD_MAX));
            ec = COORD_W'($urandom_range(0, COORD_MAX));
        end
        if ($urandom_range(0, 15) == 0)
        begin
            er = sr;
            ec = sc;
        end
        send_query(sr, sc, er, ec);
    endtask

    // Stop sending and wait until every answer has come back
    task automatic drain();
        query_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_answers != 0)
            @(posedge clk);
    endtask

    // One register write; valid is left high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.reg_data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    task automatic set_board(input logic [CFG_DATA_W-1:0] rows,
                             input logic [CFG_DATA_W-1:0] cols);
        drain();
        write_reg(REG_BOARD_ROWS, rows);
        write_reg(REG_BOARD_COLS, cols);
        cfg_ch.valid <= 1'b0;
        board_rows = (int'(rows) > MAX_ROWS) ? MAX_ROWS : int'(rows);
        board_cols = (int'(cols) > MAX_COLS) ? MAX_COLS : int'(cols);
        board_settings++;
    endtask

    // Result side: random stall before each item, with calm stretches
    initial
    begin
        int gap;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = result_calm ? 0 : $urandom_range(0, 15);
            if ($urandom_range(0, 9) == 0)
                result_calm = !result_calm;
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
        end
    end

    // Stimulus
    initial
    begin
        rst_n              <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.reg_index   <= '0;
        cfg_ch.reg_data    <= '0;
        query_ch.valid     <= 1'b0;
        query_ch.start_row <= '0;
        query_ch.start_col <= '0;
        query_ch.end_row   <= '0;
        query_ch.end_col   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset board 8x8: equal squares, far corners, off-board ends
        send_query(0, 0, 0, 0);
        send_query(0, 0, 7, 7);
        send_query(7, 7, 0, 0);
        send_query(0, 0, 1, 2);
        send_query(0, 0, 1, 1);
        send_query(8, 0, 0, 0);
        send_query(0, 0, 0, 8);
        send_query(63, 63, 63, 63);
        send_query(3, 4, 3, 4);
        repeat (20) random_query();

        // 3x3: the center square cannot be reached or left
        set_board(3, 3);
        send_query(1, 1, 0, 0);
        send_query(0, 0, 1, 1);
        send_query(0, 0, 2, 2);
        repeat (8) random_query();

        // Empty boards in either dimension
        set_board(0, 5);
        send_query(0, 0, 0, 0);
        send_query(0, 1, 0, 2);
        set_board(5, 0);
        send_query(0, 0, 0, 0);

        // Single square, then a single row
        set_board(1, 1);
        send_query(0, 0, 0, 0);
        send_query(0, 0, 0, 1);
        set_board(1, 64);
        send_query(0, 0, 0, 63);
        repeat (3) random_query();

        // Rows above the limit saturate to 64
        set_board(127, 2);
        send_query(0, 0, 63, 1);
        repeat (6) random_query();

        // A write past the register list leaves the 64x2 board as it is
        drain();
        write_reg(REG_UNUSED, 7'h55);
        cfg_ch.valid <= 1'b0;
        repeat (2) random_query();

        // Full board, only a few items since each one is slow
        set_board(64, 64);
        send_query(0, 0, 63, 63);
        send_query(63, 0, 0, 63);
        send_query(10, 20, 11, 22);

        // Random small boards
        repeat (6)
        begin
            set_board(CFG_DATA_W'($urandom_range(1, 12)), CFG_DATA_W'($urandom_range(1, 12)));
            repeat (8) random_query();
        end

        drain();
        repeat (50) @(posedge clk);
        $display("summary: %0d queries checked over %0d board settings", checked_count,
                 board_settings);
        $display("summary: empty, single-square, 3x3, 64x2 saturated, 64x64 and random boards");
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Hard stop if the block hangs
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("timeout: %0d answers outstanding after %0d cycles", pending_answers,
                 LIMIT_CYCLES);
        $display("status: fail");
        $finish;
    end

endmodule

// ----- knight_shortest_path_bfs_top.f -----
src/kspb_pkg.sv
src/kspb_ifs.sv
src/kspb_cfg.sv
src/kspb_search.sv
src/knight_shortest_path_bfs_top.sv
tb/kspb_path_checker.sv
tb/tb_top.sv
